// ===== rtl/htfd_pkg.sv =====
// Shared types, constants and the CRC-8 byte step for the humidity/temperature
// frame decoder. Depends on nothing; all rtl files but htfd_if take names from here.
package htfd_pkg;

  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  localparam logic [14:0] TempSpan = 15'd17500;
  localparam logic [14:0] HumSpan  = 15'd10000;
  localparam logic [16:0] DivK     = 17'd65535;
  localparam logic signed [15:0] TempOffset = 16'sd4500;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 15;

  localparam logic [CfgIdxW-1:0] RegMinTemp = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxTemp = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMinHum  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegMaxHum  = 2'd3;

  localparam logic signed [14:0] MinTempRst = -15'sd4000;
  localparam logic signed [14:0] MaxTempRst = 15'sd12500;
  localparam logic [13:0]        MinHumRst  = 14'd0;
  localparam logic [13:0]        MaxHumRst  = 14'd10000;

  localparam logic [13:0] HumMax = 14'd10000;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StTempCrc   = 3'd1,
    StHumCrc    = 3'd2,
    StTempRange = 3'd3,
    StHumRange  = 3'd4
  } status_e;

  typedef struct packed {
    logic [15:0] t_raw;
    logic [15:0] h_raw;
    logic        t_good;
    logic        h_good;
  } frame_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/htfd_if.sv =====
// Valid/ready channel interfaces for frame bytes in and decoded results out.
// Depends on nothing.
interface htfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface htfd_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;
  logic [15:0]        temperature_raw;
  logic [15:0]        humidity_raw;
  logic [2:0]         status;

  modport source (output valid, output temperature_centi, output humidity_centi,
                  output temperature_raw, output humidity_raw, output status,
                  input ready);
  modport sink   (input valid, input temperature_centi, input humidity_centi,
                  input temperature_raw, input humidity_raw, input status,
                  output ready);
endinterface

// ===== rtl/htfd_front.sv =====
// Front end: tracks byte position, runs CRC-8 and assembles raw words; emits one
// frame record per sixth byte. Depends on htfd_pkg and htfd_if.
module htfd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  htfd_in_if.sink             in_ch,
  input  logic                full_i,
  output logic                push_o,
  output htfd_pkg::frame_t    frame_o
);

  localparam logic [2:0] PosTempMsb = 3'd0;
  localparam logic [2:0] PosTempLsb = 3'd1;
  localparam logic [2:0] PosTempCrc = 3'd2;
  localparam logic [2:0] PosHumMsb  = 3'd3;
  localparam logic [2:0] PosHumLsb  = 3'd4;
  localparam logic [2:0] PosHumCrc  = 3'd5;

  logic [2:0]  pos_q, pos_d, pos;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] t_word_q, t_word_d;
  logic [15:0] h_word_q, h_word_d;
  logic        t_good_q, t_good_d;
  logic        accept;
  logic [7:0]  b;

  assign in_ch.ready = ~full_i;
  assign accept      = in_ch.valid & in_ch.ready;
  assign b           = in_ch.data_byte;

  always_comb begin
    pos = in_ch.frame_start ? PosTempMsb : pos_q;
    if (pos > PosHumCrc) begin
      pos = PosTempMsb;
    end
    pos_d    = pos_q;
    crc_d    = crc_q;
    t_word_d = t_word_q;
    h_word_d = h_word_q;
    t_good_d = t_good_q;
    push_o   = 1'b0;
    if (accept) begin
      unique case (pos)
        PosTempMsb: begin
          crc_d    = htfd_pkg::crc8_byte(htfd_pkg::CrcInit, b);
          t_word_d = {b, t_word_q[7:0]};
          pos_d    = PosTempLsb;
        end
        PosTempLsb: begin
          crc_d    = htfd_pkg::crc8_byte(crc_q, b);
          t_word_d = {t_word_q[15:8], b};
          pos_d    = PosTempCrc;
        end
        PosTempCrc: begin
          t_good_d = (crc_q == b);
          crc_d    = htfd_pkg::CrcInit;
          pos_d    = PosHumMsb;
        end
        PosHumMsb: begin
          crc_d    = htfd_pkg::crc8_byte(htfd_pkg::CrcInit, b);
          h_word_d = {b, h_word_q[7:0]};
          pos_d    = PosHumLsb;
        end
        PosHumLsb: begin
          crc_d    = htfd_pkg::crc8_byte(crc_q, b);
          h_word_d = {h_word_q[15:8], b};
          pos_d    = PosHumCrc;
        end
        default: begin
          crc_d  = htfd_pkg::CrcInit;
          pos_d  = PosTempMsb;
          push_o = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    frame_o.t_raw  = t_word_q;
    frame_o.h_raw  = h_word_q;
    frame_o.t_good = t_good_q;
    frame_o.h_good = (crc_q == b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= PosTempMsb;
      crc_q    <= htfd_pkg::CrcInit;
      t_word_q <= '0;
      h_word_q <= '0;
      t_good_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      t_word_q <= t_word_d;
      h_word_q <= h_word_d;
      t_good_q <= t_good_d;
    end
  end

endmodule

// ===== rtl/htfd_fifo.sv =====
// Two-entry frame queue between front and back ends.
// Depends on htfd_pkg.
module htfd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  htfd_pkg::frame_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output htfd_pkg::frame_t data_o
);

  htfd_pkg::frame_t mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_push, do_pop;

  assign full_o  = count_q[1];
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== rtl/htfd_back.sv =====
// Back end: scales raw words, divides by 65535, checks limits and holds the result
// in the output register. Holds the limit registers. Depends on htfd_pkg and htfd_if.
module htfd_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             empty_i,
  input  htfd_pkg::frame_t                 frame_i,
  output logic                             pop_o,
  input  logic                             cfg_we_i,
  input  logic [htfd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [htfd_pkg::CfgDataW-1:0]    cfg_wdata_i,
  htfd_out_if.source                       out_ch
);

  // floor(x / 65535) for x below 65535 * 2^15
  function automatic logic [14:0] div_k(input logic [30:0] x);
    logic [16:0] rem;
    rem = {1'b0, x[15:0]} + {2'b00, x[30:16]};
    return (rem >= htfd_pkg::DivK) ? (x[30:16] + 15'd1) : x[30:16];
  endfunction

  logic signed [14:0] min_t_q, max_t_q;
  logic [13:0]        min_h_q, max_h_q;

  logic               en;
  logic               v1_q, v2_q, v3_q;
  logic [30:0]        t_prod_q;
  logic [29:0]        h_prod_q;
  htfd_pkg::frame_t   f1_q, f2_q;
  logic [14:0]        t_quo_q;
  logic [13:0]        h_quo_q;
  logic signed [15:0] t_wide;
  logic signed [14:0] t_centi;
  htfd_pkg::status_e  status_d, status_q;
  logic signed [14:0] t_out_q;
  logic [13:0]        h_out_q;
  logic [15:0]        t_raw_q, h_raw_q;
  logic [14:0]        h_quo_w;

  assign en    = ~v3_q | out_ch.ready;
  assign pop_o = en & ~empty_i;

  assign h_quo_w = div_k({1'b0, h_prod_q});
  assign t_wide  = $signed({1'b0, t_quo_q}) - htfd_pkg::TempOffset;
  assign t_centi = t_wide[14:0];

  always_comb begin
    if (!f2_q.t_good) begin
      status_d = htfd_pkg::StTempCrc;
    end else if (!f2_q.h_good) begin
      status_d = htfd_pkg::StHumCrc;
    end else if (t_centi < min_t_q || t_centi > max_t_q) begin
      status_d = htfd_pkg::StTempRange;
    end else if (h_quo_q < min_h_q || h_quo_q > max_h_q) begin
      status_d = htfd_pkg::StHumRange;
    end else begin
      status_d = htfd_pkg::StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_t_q <= htfd_pkg::MinTempRst;
      max_t_q <= htfd_pkg::MaxTempRst;
      min_h_q <= htfd_pkg::MinHumRst;
      max_h_q <= htfd_pkg::MaxHumRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        htfd_pkg::RegMinTemp: min_t_q <= $signed(cfg_wdata_i);
        htfd_pkg::RegMaxTemp: max_t_q <= $signed(cfg_wdata_i);
        htfd_pkg::RegMinHum:  min_h_q <= cfg_wdata_i[13:0];
        htfd_pkg::RegMaxHum:  max_h_q <= cfg_wdata_i[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= ~empty_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_prod_q <= {16'd0, htfd_pkg::TempSpan} * {15'd0, frame_i.t_raw};
      h_prod_q <= 30'({16'd0, htfd_pkg::HumSpan} * {15'd0, frame_i.h_raw});
      f1_q     <= frame_i;
      t_quo_q  <= div_k(t_prod_q);
      h_quo_q  <= h_quo_w[13:0];
      f2_q     <= f1_q;
      t_out_q  <= t_centi;
      h_out_q  <= h_quo_q;
      t_raw_q  <= f2_q.t_raw;
      h_raw_q  <= f2_q.h_raw;
      status_q <= status_d;
    end
  end

  assign out_ch.valid             = v3_q;
  assign out_ch.temperature_centi = t_out_q;
  assign out_ch.humidity_centi    = h_out_q;
  assign out_ch.temperature_raw   = t_raw_q;
  assign out_ch.humidity_raw      = h_raw_q;
  assign out_ch.status            = status_q;

endmodule

// ===== rtl/humidity_temp_frame_decoder_core.sv =====
// Top level of the humidity/temperature frame decoder: front end, frame queue and
// back end. Depends on htfd_pkg, htfd_if, htfd_front, htfd_fifo and htfd_back.
//
//   channel  direction  carries
//   in_ch    sink       data_byte, frame_start (one frame byte per transfer)
//   out_ch   source     converted and raw words, status (one per frame)
//   cfg      write      cfg_we_i, cfg_idx_i, cfg_wdata_i (limit registers)
//
// One byte per cycle is taken while the queue is not full; the CRC byte step sits
// in the front end. Each frame is queued, then registered through the back end.
// Back end is a three-stage pipeline (multiply, divide by 65535, limit check) that
// stalls as a whole on out_ch.ready; the two-entry queue absorbs it, and in_ch.ready
// falls only while the queue is full.
// Reset: asynchronous, active low; limits return to their defaults, position to byte 0.
module humidity_temp_frame_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  htfd_in_if.sink                       in_ch,
  htfd_out_if.source                    out_ch,
  input  logic                          cfg_we_i,
  input  logic [htfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [htfd_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic             push, full, pop, empty;
  htfd_pkg::frame_t frame_in, frame_out;

  htfd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .full_i  (full),
    .push_o  (push),
    .frame_o (frame_in)
  );

  htfd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (frame_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (frame_out)
  );

  htfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .frame_i     (frame_out),
    .pop_o       (pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ch      (out_ch)
  );

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("frame pushed into full queue");

  a_hum_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> (out_ch.humidity_centi <= htfd_pkg::HumMax))
    else $error("humidity result out of bounds");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.ready) |=>
      (out_ch.valid && $stable(out_ch.temperature_raw) &&
       $stable(out_ch.humidity_raw) && $stable(out_ch.status)))
    else $error("held result dropped or changed");

endmodule

// ===== tb/sv/tb_humidity_temp_frame_decoder_core.sv =====
`timescale 1ns / 100ps
// Testbench for humidity_temp_frame_decoder_core: drives frame bytes and limit writes,
// predicts or takes from the directed table every decoded reading and checks it field by field.
// Depends on htfd_pkg, htfd_if and the decoder RTL.
module tb_humidity_temp_frame_decoder_core;
  import htfd_pkg::*;

  localparam logic [7:0]  CrcGen       = 8'h31;
  localparam logic [7:0]  CrcSeed      = 8'hFF;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned IdlePct      = 34;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 200;

  typedef struct packed {
    logic signed [14:0] t_centi;
    logic [13:0]        h_centi;
    logic [15:0]        t_raw;
    logic [15:0]        h_raw;
    status_e            st;
  } reading_t;

  typedef struct packed {
    logic [7:0] b;
    logic       s;
    logic       typed;
    reading_t   want;
  } stim_row_t;

  localparam reading_t NoReading = '0;

  logic clk_i;
  logic rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  htfd_in_if  byte_ch ();
  htfd_out_if result_ch ();

  humidity_temp_frame_decoder_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (byte_ch),
    .out_ch      (result_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // predictor state and limit copies
  logic [2:0]         pos_q;
  logic [7:0]         crc_q;
  logic [15:0]        t_word_q;
  logic [15:0]        h_word_q;
  logic               t_ok_q;
  logic signed [14:0] t_lo;
  logic signed [14:0] t_hi;
  logic [13:0]        h_lo;
  logic [13:0]        h_hi;

  reading_t    pending_readings[$];
  int unsigned bad_readings;
  int unsigned bytes_sent;
  int unsigned cycles;
  bit          calm;
  int unsigned hold_reqs;

  stim_row_t dir_rows [0:25] = '{
    '{8'h00, 1'b1, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b0, NoReading},
    '{8'h81, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b0, NoReading},
    '{8'h81, 1'b0, 1'b1, '{-15'sd4500, 14'd0, 16'h0000, 16'h0000, StTempRange}},
    '{8'hFF, 1'b0, 1'b0, NoReading},
    '{8'hFF, 1'b0, 1'b0, NoReading},
    '{8'hAC, 1'b0, 1'b0, NoReading},
    '{8'hFF, 1'b0, 1'b0, NoReading},
    '{8'hFF, 1'b0, 1'b0, NoReading},
    '{8'hAC, 1'b0, 1'b1, '{15'sd13000, 14'd10000, 16'hFFFF, 16'hFFFF, StTempRange}},
    '{8'h12, 1'b1, 1'b0, NoReading},
    '{8'h34, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b1, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b0, NoReading},
    '{8'hFF, 1'b0, 1'b0, NoReading},
    '{8'hFF, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b1, '{-15'sd4500, 14'd10000, 16'h0000, 16'hFFFF, StTempCrc}},
    '{8'hBE, 1'b1, 1'b0, NoReading},
    '{8'hEF, 1'b0, 1'b0, NoReading},
    '{8'h92, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b0, NoReading}
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("tb_humidity_temp_frame_decoder_core: FAIL");
        $finish;
      end
    end
  end

  function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r  = {r[6:0], 1'b0} ^ (fb ? CrcGen : 8'h00);
    end
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic s, output logic done,
                             output reading_t r);
    logic [2:0] p;
    int         t_val;
    int         h_val;
    logic       h_ok;
    p = s ? 3'd0 : pos_q;
    if (p > 3'd5) p = 3'd0;
    done = 1'b0;
    r    = NoReading;
    case (p)
      3'd0: begin
        crc_q = crc_next(CrcSeed, b);
        t_word_q[15:8] = b;
        pos_q = 3'd1;
      end
      3'd1: begin
        crc_q = crc_next(crc_q, b);
        t_word_q[7:0] = b;
        pos_q = 3'd2;
      end
      3'd2: begin
        t_ok_q = (crc_q == b);
        crc_q  = CrcSeed;
        pos_q  = 3'd3;
      end
      3'd3: begin
        crc_q = crc_next(CrcSeed, b);
        h_word_q[15:8] = b;
        pos_q = 3'd4;
      end
      3'd4: begin
        crc_q = crc_next(crc_q, b);
        h_word_q[7:0] = b;
        pos_q = 3'd5;
      end
      default: begin
        h_ok  = (crc_q == b);
        crc_q = CrcSeed;
        pos_q = 3'd0;
        t_val = -4500 + int'((longint'(t_word_q) * 17500) / 65535);
        h_val = int'((longint'(h_word_q) * 10000) / 65535);
        if (!t_ok_q) r.st = StTempCrc;
        else if (!h_ok) r.st = StHumCrc;
        else if (t_val < int'(t_lo) || t_val > int'(t_hi)) r.st = StTempRange;
        else if (h_val < int'(h_lo) || h_val > int'(h_hi)) r.st = StHumRange;
        else r.st = StOk;
        r.t_centi = t_val[14:0];
        r.h_centi = h_val[13:0];
        r.t_raw   = t_word_q;
        r.h_raw   = h_word_q;
        done      = 1'b1;
      end
    endcase
  endtask

  function automatic logic [15:0] pick_word(input int lim, input int offset, input int span);
    longint v;
    if ($urandom_range(9) < 4) return 16'($urandom);
    if ($urandom_range(4) == 0) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    // land close to a limit
    v = (longint'(lim + offset) * 65535) / span + int'($urandom_range(6)) - 3;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic s, input logic typed,
                           input reading_t want);
    logic     done;
    reading_t r;
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < IdlePct) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.data_byte   <= b;
    byte_ch.frame_start <= s;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    decode_byte(b, s, done, r);
    if (done) pending_readings.push_back(typed ? want : r);
    bytes_sent++;
  endtask

  task automatic send_random_unit();
    int          pick;
    int          n;
    logic [15:0] tw;
    logic [15:0] hw;
    logic [7:0]  fb [0:5];
    logic        s0;
    pick = $urandom_range(99);
    if (pick < 75) begin
      tw = pick_word($urandom_range(1) ? int'(t_lo) : int'(t_hi), 4500, 17500);
      hw = pick_word($urandom_range(1) ? int'(h_lo) : int'(h_hi), 0, 10000);
      fb[0] = tw[15:8];
      fb[1] = tw[7:0];
      fb[2] = crc_next(crc_next(CrcSeed, tw[15:8]), tw[7:0]);
      fb[3] = hw[15:8];
      fb[4] = hw[7:0];
      fb[5] = crc_next(crc_next(CrcSeed, hw[15:8]), hw[7:0]);
      if ($urandom_range(9) == 0) fb[2] ^= 8'($urandom_range(255, 1));
      if ($urandom_range(9) == 0) fb[5] ^= 8'($urandom_range(255, 1));
      s0 = ($urandom_range(4) != 0);
      for (int i = 0; i < 6; i++) push_byte(fb[i], (i == 0) ? s0 : 1'b0, 1'b0, NoReading);
    end else if (pick < 88) begin
      // broken frame, cut short
      n = $urandom_range(5, 1);
      for (int i = 0; i < n; i++) push_byte(8'($urandom), i == 0, 1'b0, NoReading);
    end else begin
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++) push_byte(8'($urandom), 1'($urandom), 1'b0, NoReading);
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    byte_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_limits(input int t_lo_v, input int t_hi_v, input int h_lo_v,
                              input int h_hi_v);
    logic [CfgIdxW-1:0]  regs [0:3];
    logic [CfgDataW-1:0] vals [0:3];
    regs = '{RegMinTemp, RegMaxTemp, RegMinHum, RegMaxHum};
    vals = '{t_lo_v[14:0], t_hi_v[14:0], {1'b0, h_lo_v[13:0]}, {1'b0, h_hi_v[13:0]}};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we    <= 1'b1;
      cfg_idx   <= regs[i];
      cfg_wdata <= vals[i];
    end
    @(negedge clk_i);
    cfg_we <= 1'b0;
    t_lo = t_lo_v[14:0];
    t_hi = t_hi_v[14:0];
    h_lo = h_lo_v[13:0];
    h_hi = h_hi_v[13:0];
  endtask

  task automatic random_limits();
    int a;
    int b;
    int c;
    int d;
    int x;
    a = int'($urandom_range(17500)) - 4500;
    b = int'($urandom_range(17500)) - 4500;
    c = int'($urandom_range(10000));
    d = int'($urandom_range(10000));
    if (a > b && $urandom_range(4) != 0) begin
      x = a;
      a = b;
      b = x;
    end
    if (c > d && $urandom_range(4) != 0) begin
      x = c;
      c = d;
      d = x;
    end
    write_limits(a, b, c, d);
  endtask

  task automatic run_phase(input int unsigned n_bytes, input bit quiet, input bit squeeze);
    int unsigned target;
    target = bytes_sent + n_bytes;
    calm   = quiet;
    if (squeeze) hold_reqs++;
    while (bytes_sent < target) send_random_unit();
    settle();
    calm = 1'b0;
  endtask

  task automatic check_field(input string name, input logic signed [16:0] want,
                             input logic signed [16:0] got);
    if (got !== want) begin
      bad_readings++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_reading();
    reading_t w;
    if (pending_readings.size() == 0) begin
      bad_readings++;
      $display("%0t: reading with none pending, expected nothing got raw %h %h", $time,
               result_ch.temperature_raw, result_ch.humidity_raw);
    end else begin
      w = pending_readings.pop_front();
      check_field("temperature_centi", w.t_centi, result_ch.temperature_centi);
      check_field("humidity_centi", w.h_centi, result_ch.humidity_centi);
      check_field("temperature_raw", w.t_raw, result_ch.temperature_raw);
      check_field("humidity_raw", w.h_raw, result_ch.humidity_raw);
      check_field("status", w.st, result_ch.status);
    end
  endtask

  initial begin
    int          hold_left;
    int unsigned holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_ch.valid && result_ch.ready) check_reading();
      @(negedge clk_i);
      if (hold_reqs != holds_seen) begin
        hold_left  = HoldCycles;
        holds_seen = hold_reqs;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= calm || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  initial begin
    rst_ni              = 1'b0;
    byte_ch.valid       = 1'b0;
    byte_ch.data_byte   = 8'h00;
    byte_ch.frame_start = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = RegMinTemp;
    cfg_wdata           = '0;
    pos_q               = 3'd0;
    crc_q               = CrcSeed;
    t_word_q            = 16'h0000;
    h_word_q            = 16'h0000;
    t_ok_q              = 1'b0;
    t_lo                = -15'sd4000;
    t_hi                = 15'sd12500;
    h_lo                = 14'd0;
    h_hi                = 14'd10000;
    bad_readings        = 0;
    bytes_sent          = 0;
    calm                = 1'b0;
    hold_reqs           = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < 26; i++) begin
      push_byte(dir_rows[i].b, dir_rows[i].s, dir_rows[i].typed, dir_rows[i].want);
    end
    settle();

    // hold the output back while bytes keep coming, so the input stalls
    write_limits(-4500, 13000, 0, 10000);
    run_phase(100, 1'b1, 1'b1);
    write_limits(13000, -4500, 0, 10000);
    run_phase(80, 1'b0, 1'b0);
    write_limits(-4500, 13000, 10000, 0);
    run_phase(80, 1'b0, 1'b0);
    for (int k = 0; k < 4; k++) begin
      random_limits();
      run_phase(85, 1'b0, 1'b0);
    end
    repeat (SettleCycles) @(posedge clk_i);

    if (bad_readings == 0) begin
      $display("tb_humidity_temp_frame_decoder_core: PASS");
    end else begin
      $display("tb_humidity_temp_frame_decoder_core: FAIL");
    end
    $finish;
  end

endmodule
